### rtl/wbdt_pkg.sv
// shared types and constants for the write-back dirty table
package wbdt_pkg;

   localparam int unsigned MAX_AGE_RESET = 5 * 1000;
   localparam int unsigned MAX_RESULTS   = 64;

   typedef enum logic [2:0] {
      MODE_MARK_WRITE  = 3'd0,
      MODE_MARK_DELETE = 3'd1,
      MODE_LOOKUP      = 3'd2,
      MODE_TICK        = 3'd3,
      MODE_FLUSH_ALL   = 3'd4,
      MODE_COMPLETE    = 3'd5,
      MODE_LIST        = 3'd6,
      MODE_UNKNOWN     = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      KIND_STORED    = 4'd0,
      KIND_BYPASS    = 4'd1,
      KIND_HIT       = 4'd2,
      KIND_TOMBSTONE = 4'd3,
      KIND_MISS      = 4'd4,
      KIND_FLUSH     = 4'd5,
      KIND_PENDING   = 4'd6,
      KIND_NONE      = 4'd7,
      KIND_FREED     = 4'd8,
      KIND_STILL     = 4'd9,
      KIND_IGNORED   = 4'd10
   } kind_type;

   localparam logic [1:0] OP_CLEAN  = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic CSR_MAX_AGE   = 1'b0;
   localparam logic CSR_BUFFERING = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] rule_key;
      logic [63:0] rule_payload;
      logic [31:0] now_ms;
      logic [5:0]  entry_index;
      logic        write_ok;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [5:0]  entry_slot;
      logic [1:0]  op_code;
      logic [15:0] rule_id_out;
      logic [63:0] payload_out;
      logic        last;
   } rsp_type;

endpackage

### rtl/write_back_dirty_table.sv
// write-back dirty table: entry memory with a scanning sequencer
// mark reads each entry at most once per scan: a key scan, then a clean-entry scan if no key
// matches; lookup, tick, flush all and list use one scan, completion none.
// one item at a time; busy is high from acceptance until the last word has been strobed.
// each result word is on rsp_ for one cycle; the receiver cannot stall.
// sync reset clears flags and control, presets config; no clearing pass (op/flag bits are flops).
module write_back_dirty_table #(
   parameter int TABLE_ENTRIES = 64,
   parameter int PAYLOAD_BITS  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  wbdt_pkg::req_type     req_item,
   output logic                  rsp_valid,
   output wbdt_pkg::rsp_type     rsp_item,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [31:0]           csr_data
);
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_KEY  = 6'b000010,
      S_CLN  = 6'b000100,
      S_SCAN = 6'b001000,
      S_ONE  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   // per-entry control bits live in flops, key/time/data in memory
   logic [1:0] op_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] fly_ff, rem_ff;
   logic [15:0] key_mem [TABLE_ENTRIES];
   logic [31:0] time_mem [TABLE_ENTRIES];
   logic [PAYLOAD_BITS-1:0] data_mem [TABLE_ENTRIES];
   logic [15:0] key_rd;
   logic [31:0] time_rd;
   logic [PAYLOAD_BITS-1:0] data_rd;

   state_type state_ff;
   wbdt_pkg::req_type req_ff;
   logic [31:0] max_age_ff;
   logic buf_en_ff;
   logic [CW-1:0] cnt_ff;       // entry address issued
   logic [IW-1:0] rd_idx_ff;    // entry whose data is on the read port
   logic rd_vld_ff;
   logic any_ff;
   logic [6:0] nres_ff;         // scan words found so far
   logic rsp_valid_ff;
   wbdt_pkg::rsp_type rsp_ff;
   wbdt_pkg::rsp_type hold_ff;  // scan word waiting for its last flag

   logic [IW-1:0] rd_addr;
   logic [IW-1:0] ci_in;
   logic we;
   logic [IW-1:0] wa;

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;
   // while idle the port reads the completion entry so its key is ready
   assign ci_in = IW'(req_item.entry_index);
   assign rd_addr = (state_ff == S_IDLE) ? ci_in : cnt_ff[IW-1:0];

   always_ff @(posedge clock) begin
      key_rd <= key_mem[rd_addr];
      time_rd <= time_mem[rd_addr];
      data_rd <= data_mem[rd_addr];
      if (we) begin
         key_mem[wa] <= req_ff.rule_key;
         time_mem[wa] <= req_ff.now_ms;
         data_mem[wa] <= (req_ff.mode == wbdt_pkg::MODE_MARK_WRITE) ?
                         req_ff.rule_payload[PAYLOAD_BITS-1:0] : '0;
      end
   end

   function automatic logic [63:0] ext(input logic [PAYLOAD_BITS-1:0] d);
      logic [63:0] r;
      r = '0;
      r[PAYLOAD_BITS-1:0] = d;
      return r;
   endfunction

   function automatic wbdt_pkg::rsp_type mk(input wbdt_pkg::kind_type k,
         input logic [IW-1:0] s, input logic [1:0] o, input logic [15:0] id,
         input logic [63:0] p, input logic l);
      wbdt_pkg::rsp_type r;
      r.kind = k;
      r.entry_slot = 6'(s);
      r.op_code = o;
      r.rule_id_out = id;
      r.payload_out = p;
      r.last = l;
      return r;
   endfunction

   logic [1:0] mop;
   logic [1:0] rop;
   logic [IW-1:0] ci;
   logic ci_ok;
   logic rd_pend, last_rd, aged;
   assign mop = (req_ff.mode == wbdt_pkg::MODE_MARK_WRITE) ? wbdt_pkg::OP_WRITE
                                                           : wbdt_pkg::OP_DELETE;
   assign rop = op_ff[rd_idx_ff];
   assign ci = IW'(req_ff.entry_index);
   assign ci_ok = (32'(req_ff.entry_index) < TABLE_ENTRIES);
   assign rd_pend = rd_vld_ff && (rop != wbdt_pkg::OP_CLEAN);
   assign last_rd = (32'(rd_idx_ff) == TABLE_ENTRIES - 1);
   assign aged = ((req_ff.now_ms - time_rd) >= max_age_ff);

   always_comb begin
      we = 1'b0;
      wa = rd_idx_ff;
      if (state_ff == S_KEY && rd_pend && key_rd == req_ff.rule_key &&
          req_ff.mode != wbdt_pkg::MODE_LOOKUP) we = 1'b1;
      if (state_ff == S_CLN && rd_vld_ff && rop == wbdt_pkg::OP_CLEAN) we = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         max_age_ff <= 32'(wbdt_pkg::MAX_AGE_RESET);
         buf_en_ff <= 1'b1;
         fly_ff <= '0;
         rem_ff <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) op_ff[i] <= wbdt_pkg::OP_CLEAN;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         any_ff <= 1'b0;
         nres_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            if (csr_index == wbdt_pkg::CSR_MAX_AGE) max_age_ff <= csr_data;
            else buf_en_ff <= csr_data[0];
         end
         if (we) begin
            op_ff[wa] <= mop;
            rem_ff[wa] <= fly_ff[wa];
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_item;
                  cnt_ff <= '0;
                  rd_vld_ff <= 1'b0;
                  any_ff <= 1'b0;
                  nres_ff <= '0;
                  case (req_item.mode)
                     wbdt_pkg::MODE_MARK_WRITE, wbdt_pkg::MODE_MARK_DELETE,
                     wbdt_pkg::MODE_LOOKUP:
                        state_ff <= S_KEY;
                     wbdt_pkg::MODE_TICK, wbdt_pkg::MODE_FLUSH_ALL, wbdt_pkg::MODE_LIST:
                        state_ff <= S_SCAN;
                     default: state_ff <= S_ONE;
                  endcase
               end
            end
            S_KEY, S_CLN, S_SCAN: begin
               // issue next read; result of previous read is evaluated below
               if (32'(cnt_ff) < TABLE_ENTRIES) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  rd_idx_ff <= rd_addr;
                  rd_vld_ff <= 1'b1;
               end else begin
                  rd_vld_ff <= 1'b0;
               end
               if (state_ff == S_KEY) begin
                  if (req_ff.mode != wbdt_pkg::MODE_LOOKUP && !buf_en_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= mk(wbdt_pkg::KIND_BYPASS, '0, mop, req_ff.rule_key,
                                  (req_ff.mode == wbdt_pkg::MODE_MARK_WRITE) ?
                                  ext(req_ff.rule_payload[PAYLOAD_BITS-1:0]) : '0, 1'b1);
                     state_ff <= S_DONE;
                  end else if (rd_pend && key_rd == req_ff.rule_key) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_DONE;
                     if (req_ff.mode != wbdt_pkg::MODE_LOOKUP)
                        rsp_ff <= mk(wbdt_pkg::KIND_STORED, rd_idx_ff, mop,
                                     req_ff.rule_key, '0, 1'b1);
                     else if (rop == wbdt_pkg::OP_DELETE)
                        rsp_ff <= mk(wbdt_pkg::KIND_TOMBSTONE, rd_idx_ff,
                                     wbdt_pkg::OP_DELETE, req_ff.rule_key, '0, 1'b1);
                     else
                        rsp_ff <= mk(wbdt_pkg::KIND_HIT, rd_idx_ff, wbdt_pkg::OP_WRITE,
                                     req_ff.rule_key, ext(data_rd), 1'b1);
                  end else if (rd_vld_ff && last_rd) begin
                     if (req_ff.mode == wbdt_pkg::MODE_LOOKUP) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff <= mk(wbdt_pkg::KIND_MISS, '0, wbdt_pkg::OP_CLEAN,
                                     req_ff.rule_key, '0, 1'b1);
                        state_ff <= S_DONE;
                     end else begin
                        cnt_ff <= '0;
                        rd_vld_ff <= 1'b0;
                        state_ff <= S_CLN;
                     end
                  end
               end else if (state_ff == S_CLN) begin
                  if (rd_vld_ff && rop == wbdt_pkg::OP_CLEAN) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= mk(wbdt_pkg::KIND_STORED, rd_idx_ff, mop,
                                  req_ff.rule_key, '0, 1'b1);
                     state_ff <= S_DONE;
                  end else if (rd_vld_ff && last_rd) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= mk(wbdt_pkg::KIND_BYPASS, '0, mop, req_ff.rule_key,
                                  (req_ff.mode == wbdt_pkg::MODE_MARK_WRITE) ?
                                  ext(req_ff.rule_payload[PAYLOAD_BITS-1:0]) : '0, 1'b1);
                     state_ff <= S_DONE;
                  end
               end else begin
                  // scan: list, tick, flush all; each word is held until the next one
                  // is found so the last flag is known when the final entry is seen
                  if (rd_vld_ff) begin
                     if (rd_pend && nres_ff < 7'(wbdt_pkg::MAX_RESULTS) &&
                         (req_ff.mode == wbdt_pkg::MODE_LIST ||
                         (!fly_ff[rd_idx_ff] &&
                          (req_ff.mode == wbdt_pkg::MODE_FLUSH_ALL || aged)))) begin
                        if (any_ff) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff <= hold_ff;
                        end
                        any_ff <= 1'b1;
                        nres_ff <= nres_ff + 1'b1;
                        hold_ff <= mk((req_ff.mode == wbdt_pkg::MODE_LIST) ?
                                      wbdt_pkg::KIND_PENDING : wbdt_pkg::KIND_FLUSH,
                                      rd_idx_ff, rop, key_rd, ext(data_rd), 1'b0);
                        if (req_ff.mode != wbdt_pkg::MODE_LIST) begin
                           fly_ff[rd_idx_ff] <= 1'b1;
                           rem_ff[rd_idx_ff] <= 1'b0;
                        end
                     end
                     if (last_rd) state_ff <= S_ONE;
                  end
               end
            end
            S_ONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_DONE;
               case (req_ff.mode)
                  wbdt_pkg::MODE_TICK, wbdt_pkg::MODE_FLUSH_ALL, wbdt_pkg::MODE_LIST: begin
                     // close the scan: mark the final word, or report none
                     if (any_ff) begin
                        rsp_ff <= hold_ff;
                        rsp_ff.last <= 1'b1;
                     end else begin
                        rsp_ff <= mk(wbdt_pkg::KIND_NONE, '0, wbdt_pkg::OP_CLEAN, '0, '0,
                                     1'b1);
                     end
                  end
                  wbdt_pkg::MODE_COMPLETE: begin
                     if (!ci_ok || op_ff[ci] == wbdt_pkg::OP_CLEAN || !fly_ff[ci]) begin
                        rsp_ff <= mk(wbdt_pkg::KIND_IGNORED, '0, wbdt_pkg::OP_CLEAN, '0,
                                     '0, 1'b1);
                        rsp_ff.entry_slot <= req_ff.entry_index;
                     end else begin
                        fly_ff[ci] <= 1'b0;
                        rsp_ff <= mk(wbdt_pkg::KIND_STILL, ci, op_ff[ci], key_rd,
                                     '0, 1'b1);
                        if (rem_ff[ci]) rem_ff[ci] <= 1'b0;
                        else if (op_ff[ci] == wbdt_pkg::OP_DELETE || req_ff.write_ok) begin
                           op_ff[ci] <= wbdt_pkg::OP_CLEAN;
                           rsp_ff.kind <= wbdt_pkg::KIND_FREED;
                        end
                     end
                  end
                  default:
                     rsp_ff <= mk(wbdt_pkg::KIND_IGNORED, '0, wbdt_pkg::OP_CLEAN, '0, '0,
                                  1'b1);
               endcase
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
